// ===== design/positional_list_table_assert.svh =====
// Assertion macros for the positional list table.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef POSITIONAL_LIST_TABLE_ASSERT_SVH
`define POSITIONAL_LIST_TABLE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define PLT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/plt_pkg.sv =====
// Shared types and constants for the positional list table.
// Used by plt_cell and positional_list_table; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

	localparam int unsigned LIST_DEPTH = 16;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);

	// request actions
	localparam logic [1:0] ACT_READ   = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_APPEND = 2'd3;

	// result status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// shift command broadcast to every cell of the row
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [CNT_W-1:0] pos;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/plt_cell.sv =====
// One slot of the list: holds a single entry and trades it with its neighbors.
// Depends on plt_pkg for the shift command type.
`timescale 1ns / 1ps
`default_nettype none

module plt_cell #(
	parameter int unsigned INDEX      = 0,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire plt_pkg::cell_ctrl_t   ctrl,
	input  wire logic [DATA_WIDTH-1:0] from_below,
	input  wire logic [DATA_WIDTH-1:0] from_above,
	input  wire logic [DATA_WIDTH-1:0] word_in,
	output logic      [DATA_WIDTH-1:0] entry
);

	localparam logic [plt_pkg::CNT_W-1:0] MY_POS = plt_pkg::CNT_W'(INDEX);

	logic [DATA_WIDTH-1:0] entry_q;

	// insert: slots above the gap take the lower neighbor, the gap takes the word
	// remove: the slot removed and all above take the upper neighbor
	always_ff @(posedge clk) begin
		if (ctrl.ins && (MY_POS > ctrl.pos)) begin
			entry_q <= from_below;
		end else if (ctrl.ins && (MY_POS == ctrl.pos)) begin
			entry_q <= word_in;
		end else if (ctrl.rem && (MY_POS >= ctrl.pos)) begin
			entry_q <= from_above;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// ===== design/positional_list_table.sv =====
// Top level of the positional list table: request decode, cell row, result register.
// Depends on plt_pkg, plt_cell and positional_list_table_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// Positional list table. Holds an ordered list of up to plt_pkg::LIST_DEPTH words,
// slot 0 first, in a row of cells. Every request word yields exactly one result
// word in the cycle after it is accepted. Read and remove return the entry at the
// given position; insert opens a gap at the position (0 up to the count) and
// append places the word at the end. A position out of range reports status
// ST_BAD_POS, insert or append on a full list reports ST_FULL; in both cases the
// list is left as it was and data_out is zero. Every result carries the count
// after the request. A request is taken every clock unless the result stalls:
// each cell reloads from its neighbor on the same edge, so an insert or remove
// anywhere is one row update, and the single result register is refilled in
// the cycle it is drained. Stale slots above the count keep old words, never read.
module positional_list_table #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request: [1:0] action, [6:2] position, [38:7] data_in, [39] zero
	input  wire logic [39:0] s_tdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// result: [31:0] data_out, [33:32] status, [38:34] count, [39] zero
	output logic      [39:0] m_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready
);

`include "positional_list_table_assert.svh"

	localparam int unsigned CNT_W = plt_pkg::CNT_W;
	localparam int unsigned IDX_W = plt_pkg::IDX_W;
	localparam int unsigned DEPTH = plt_pkg::LIST_DEPTH;

	// request fields
	logic [1:0]       action;
	logic [CNT_W-1:0] position;
	logic [31:0]      data_in;

	assign action   = s_tdata[1:0];
	assign position = s_tdata[6:2];
	assign data_in  = s_tdata[38:7];

	logic accept;
	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	logic [CNT_W-1:0] count_q;

	// decode the request against the current count
	logic [CNT_W-1:0]    ins_pos;
	logic                in_range;
	logic                take_entry;
	logic [1:0]          status_d;
	plt_pkg::cell_ctrl_t ctrl;

	assign in_range = position < count_q;
	assign ins_pos  = (action == plt_pkg::ACT_APPEND) ? count_q : position;

	always_comb begin
		status_d   = plt_pkg::ST_OK;
		take_entry = 1'b0;
		ctrl.ins   = 1'b0;
		ctrl.rem   = 1'b0;
		ctrl.pos   = ins_pos;
		unique case (action)
			plt_pkg::ACT_READ: begin
				if (in_range) begin
					take_entry = 1'b1;
				end else begin
					status_d = plt_pkg::ST_BAD_POS;
				end
			end
			plt_pkg::ACT_REMOVE: begin
				if (in_range) begin
					take_entry = 1'b1;
					ctrl.rem   = accept;
				end else begin
					status_d = plt_pkg::ST_BAD_POS;
				end
			end
			default: begin
				// insert and append; append always lands at the count
				if (ins_pos > count_q) begin
					status_d = plt_pkg::ST_BAD_POS;
				end else if (count_q == plt_pkg::FULL_COUNT) begin
					status_d = plt_pkg::ST_FULL;
				end else begin
					ctrl.ins = accept;
				end
			end
		endcase
	end

	// row of cells; each one sees both neighbors
	logic [DATA_WIDTH-1:0] entry_w [DEPTH];
	logic [DATA_WIDTH-1:0] word_w;

	assign word_w = DATA_WIDTH'(data_in);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] below_w;
		logic [DATA_WIDTH-1:0] above_w;

		if (i == 0) begin : g_bottom
			assign below_w = '0;
		end else begin : g_lower
			assign below_w = entry_w[i-1];
		end

		// the top slot simply holds on a remove
		if (i == DEPTH - 1) begin : g_top
			assign above_w = entry_w[i];
		end else begin : g_upper
			assign above_w = entry_w[i+1];
		end

		plt_cell #(
			.INDEX      (i),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.from_below (below_w),
			.from_above (above_w),
			.word_in    (word_w),
			.entry      (entry_w[i])
		);
	end

	// entry at the requested position; position is below the count when used
	logic [31:0] data_out_d;
	assign data_out_d = take_entry ? 32'(entry_w[position[IDX_W-1:0]]) : 32'd0;

	// count update
	logic [CNT_W-1:0] count_d;

	always_comb begin
		count_d = count_q;
		if (ctrl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctrl.rem) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// result register: load on accept, drop valid once the word is taken
	logic             out_valid_q;
	logic [31:0]      data_out_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] count_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_out_q  <= data_out_d;
			status_q    <= status_d;
			count_out_q <= count_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, count_out_q, status_q, data_out_q};

	// checks
	`PLT_ASSERT_SAME(a_count_bound, 1'b1, count_q <= plt_pkg::FULL_COUNT, "count above depth")
	`PLT_ASSERT_NEXT(a_ins_grows, accept && ctrl.ins, count_q == CNT_W'($past(count_q) + 1), "insert did not grow count")
	`PLT_ASSERT_SAME(a_shift_excl, 1'b1, !(ctrl.ins && ctrl.rem), "insert and remove at once")
	`PLT_ASSERT_SAME(a_bad_zero, out_valid_q && (status_q != plt_pkg::ST_OK), data_out_q == 32'd0, "data on failed request")

endmodule

`default_nettype wire
